// ===== hw/rtl/gclp_pkg.sv =====
// Package for the G-code line parser: character codes and item types shared by
// the parse core and the top level, and the number helpers of the parse core.
// Depends on nothing.
package gclp_pkg;

    localparam int LINE_BUFFER_DEF = 64;
    localparam int VALUE_TEXT_MAX  = 15;
    localparam int CMD_MAX         = 7;
    localparam int PARAM_COUNT     = 6;
    localparam int CASE_OFFSET     = 32;

    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_VT    = 8'd11;
    localparam logic [7:0] CH_FF    = 8'd12;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;
    localparam logic [7:0] CH_LC_A  = 8'd97;
    localparam logic [7:0] CH_LC_Z  = 8'd122;
    localparam logic [7:0] CH_DOT   = 8'd46;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_X     = 8'd88;
    localparam logic [7:0] CH_Y     = 8'd89;
    localparam logic [7:0] CH_Z     = 8'd90;
    localparam logic [7:0] CH_F     = 8'd70;
    localparam logic [7:0] CH_S     = 8'd83;
    localparam logic [7:0] CH_P     = 8'd80;

    localparam logic [2:0] IDX_X = 3'd0;
    localparam logic [2:0] IDX_Y = 3'd1;
    localparam logic [2:0] IDX_Z = 3'd2;
    localparam logic [2:0] IDX_F = 3'd3;
    localparam logic [2:0] IDX_S = 3'd4;
    localparam logic [2:0] IDX_P = 3'd5;

    localparam logic [31:0] POS_LIMIT = 32'h7FFF_FFFF;
    localparam logic [31:0] NEG_LIMIT = 32'h8000_0000;

    typedef enum logic [3:0] {
        PH_CMD   = 4'b0001,
        PH_SKIP  = 4'b0010,
        PH_VALUE = 4'b0100,
        PH_ERR   = 4'b1000
    } phase_t;

    typedef enum logic [4:0] {
        NS_START = 5'b00001,
        NS_SIGN  = 5'b00010,
        NS_INT   = 5'b00100,
        NS_FRAC  = 5'b01000,
        NS_DONE  = 5'b10000
    } nstage_t;

    typedef struct packed {
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [55:0]        command_word;
        logic [2:0]         command_length;
        logic               line_valid;
        logic               syntax_error;
        logic [5:0]         present_mask;
        logic signed [31:0] x_value;
        logic signed [31:0] y_value;
        logic signed [31:0] z_value;
        logic signed [31:0] feed_value;
        logic signed [31:0] speed_value;
        logic signed [31:0] pause_value;
    } result_t;

    typedef struct packed {
        logic       go;
        logic [7:0] ch;
    } step_t;

    typedef struct packed {
        logic       hit;
        logic [2:0] idx;
    } slot_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) || (c == CH_FF);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic [7:0] to_upper(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if ((c >= CH_LC_A) && (c <= CH_LC_Z))
        begin
            r = c - 8'(CASE_OFFSET);
        end
        return r;
    endfunction

    // Saturating multiply-by-ten accumulate.
    function automatic logic [31:0] mul10_add(input logic [31:0] mag, input logic [3:0] d);
        logic [35:0] m;
        m = {1'b0, mag, 3'b000} + {3'b000, mag, 1'b0} + {32'd0, d};
        return (m[35:32] != 4'd0) ? 32'hFFFF_FFFF : m[31:0];
    endfunction

    // Scale to thousandths, clamp and apply the sign.
    function automatic logic [31:0] scale_clamp(input logic [31:0] mag,
                                                input logic [1:0] frac,
                                                input logic neg);
        logic [9:0]  factor;
        logic [41:0] prod;
        logic [31:0] r;
        case (frac)
            2'd0:    factor = 10'd1000;
            2'd1:    factor = 10'd100;
            2'd2:    factor = 10'd10;
            default: factor = 10'd1;
        endcase
        prod = 42'(mag) * 42'(factor);
        if (neg)
        begin
            r = (prod > 42'(NEG_LIMIT)) ? NEG_LIMIT : 32'(32'd0 - prod[31:0]);
        end
        else
        begin
            r = (prod > 42'(POS_LIMIT)) ? POS_LIMIT : prod[31:0];
        end
        return r;
    endfunction

    function automatic slot_t letter_slot(input logic [7:0] c);
        slot_t s;
        s.hit = 1'b1;
        case (c)
            CH_X:    s.idx = IDX_X;
            CH_Y:    s.idx = IDX_Y;
            CH_Z:    s.idx = IDX_Z;
            CH_F:    s.idx = IDX_F;
            CH_S:    s.idx = IDX_S;
            CH_P:    s.idx = IDX_P;
            default:
            begin
                s.hit = 1'b0;
                s.idx = IDX_X;
            end
        endcase
        return s;
    endfunction

endpackage

// ===== hw/rtl/gclp_stream_if.sv =====
// Valid/ready stream interface carrying one payload per transaction.
// Depends on nothing; the payload type is set per instance.
interface gclp_stream_if #(parameter type payload_t = logic [7:0]);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/gclp_line_parser_top.sv =====
// G-code line parser top level. Each byte is first held in the input register;
// a line's result enters the result register when its LF leaves that register.
// Throughput: one byte per cycle, set by the parse step between the input and
// result registers, which stalls only while a finished result is not yet taken.
// Reset clears all line state to an empty line; no clearing pass is needed.
// Depends on gclp_pkg, gclp_stream_if, gclp_parse_core and gclp_out_stage.
module gcode_line_parser
    import gclp_pkg::*;
#(
    parameter int LINE_BUFFER = LINE_BUFFER_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    gclp_stream_if.sink   in_ch,
    gclp_stream_if.source out_ch
);

    logic       s1_valid_reg, s1_valid_next;
    logic [7:0] s1_byte_reg;
    logic       in_fire;
    logic       s1_go;
    logic       s1_lf;
    logic       out_free;
    logic       out_load;
    step_t      step;
    result_t    result;
    in_item_t   in_item;

    assign in_item       = in_ch.data;
    assign s1_lf         = (s1_byte_reg == CH_LF);
    assign s1_go         = s1_valid_reg && (!s1_lf || out_free);
    assign out_load      = s1_go && s1_lf;
    assign in_ch.ready   = !s1_valid_reg || s1_go;
    assign in_fire       = in_ch.valid && in_ch.ready;
    assign s1_valid_next = in_fire ? 1'b1 : (s1_go ? 1'b0 : s1_valid_reg);
    assign step.go       = s1_go;
    assign step.ch       = s1_byte_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_byte_reg <= in_item.rx_byte;
        end
    end

    gclp_parse_core #(
        .LINE_BUFFER (LINE_BUFFER)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .result (result)
    );

    gclp_out_stage u_out (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (out_load),
        .result (result),
        .free   (out_free),
        .out_ch (out_ch)
    );

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_go |-> !in_ch.ready)
        else $error("input taken while held byte is stalled");

    a_load_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> out_ch.valid)
        else $error("loaded result not presented");

    a_valid_excludes_error: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> !(out_ch.data.line_valid && out_ch.data.syntax_error))
        else $error("line flagged both valid and in error");

    a_absent_x_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.data.present_mask[0] |-> out_ch.data.x_value == 0)
        else $error("absent X carries a value");

endmodule

// ===== hw/rtl/gclp_parse_core.sv =====
// Line state registers and per-character parse logic of the G-code parser.
// Depends on gclp_pkg.
module gclp_parse_core
    import gclp_pkg::*;
#(
    parameter int LINE_BUFFER = LINE_BUFFER_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  step_t   step,
    output result_t result
);

    localparam int LC_W = $clog2(LINE_BUFFER);
    localparam logic [LC_W-1:0] LC_MAX = LC_W'(LINE_BUFFER - 1);

    logic [LC_W-1:0] line_count_reg, line_count_next;
    phase_t          phase_reg, phase_next;
    logic [55:0]     cmd_chars_reg, cmd_chars_next;
    logic [2:0]      cmd_count_reg, cmd_count_next;
    logic [7:0]      letter_reg, letter_next;
    nstage_t         nstage_reg, nstage_next;
    logic            neg_reg, neg_next;
    logic [1:0]      frac_reg, frac_next;
    logic [3:0]      vtc_reg, vtc_next;
    logic [31:0]     mag_reg, mag_next;
    logic            err_reg, err_next;
    logic [5:0]      seen_reg, seen_next;
    logic [31:0]     param_reg [PARAM_COUNT];
    logic [31:0]     param_next [PARAM_COUNT];

    logic [7:0]  uc;
    logic        sp;
    logic        num_ch;
    logic        start_p;
    logic        commit_en;
    logic [31:0] commit_val;
    logic [31:0] digit_mag;
    slot_t       slot;
    logic [31:0] lf_param [PARAM_COUNT];
    logic [5:0]  lf_seen;

    assign uc         = to_upper(step.ch);
    assign sp         = is_space(uc);
    assign num_ch     = is_digit(uc) || (uc == CH_DOT) || (uc == CH_MINUS);
    assign commit_val = scale_clamp(mag_reg, frac_reg, neg_reg);
    assign digit_mag  = mul10_add(mag_reg, uc[3:0]);
    assign slot       = letter_slot(letter_reg);

    always_comb
    begin
        line_count_next = line_count_reg;
        phase_next      = phase_reg;
        cmd_chars_next  = cmd_chars_reg;
        cmd_count_next  = cmd_count_reg;
        letter_next     = letter_reg;
        nstage_next     = nstage_reg;
        neg_next        = neg_reg;
        frac_next       = frac_reg;
        vtc_next        = vtc_reg;
        mag_next        = mag_reg;
        err_next        = err_reg;
        seen_next       = seen_reg;
        param_next      = param_reg;
        start_p         = 1'b0;
        commit_en       = 1'b0;
        if (step.go && (step.ch == CH_LF))
        begin
            line_count_next = '0;
            phase_next      = PH_CMD;
            cmd_chars_next  = '0;
            cmd_count_next  = '0;
            letter_next     = '0;
            nstage_next     = NS_START;
            neg_next        = 1'b0;
            frac_next       = '0;
            vtc_next        = '0;
            mag_next        = '0;
            err_next        = 1'b0;
            seen_next       = '0;
            for (int k = 0; k < PARAM_COUNT; k++)
            begin
                param_next[k] = '0;
            end
        end
        else if (step.go && (step.ch != CH_CR) && (line_count_reg < LC_MAX))
        begin
            line_count_next = line_count_reg + 1'b1;
            case (phase_reg)
                PH_CMD:
                begin
                    if (sp)
                    begin
                        phase_next = PH_SKIP;
                    end
                    else if (cmd_count_reg < 3'(CMD_MAX))
                    begin
                        cmd_chars_next[8*cmd_count_reg +: 8] = uc;
                        cmd_count_next = cmd_count_reg + 1'b1;
                    end
                    else
                    begin
                        start_p = 1'b1;
                    end
                end
                PH_SKIP:
                begin
                    start_p = !sp;
                end
                PH_VALUE:
                begin
                    if (num_ch)
                    begin
                        if (vtc_reg < 4'(VALUE_TEXT_MAX))
                        begin
                            vtc_next = vtc_reg + 1'b1;
                            case (nstage_reg)
                                NS_START, NS_SIGN, NS_INT:
                                begin
                                    if (uc == CH_MINUS)
                                    begin
                                        if (nstage_reg == NS_START)
                                        begin
                                            neg_next    = 1'b1;
                                            nstage_next = NS_SIGN;
                                        end
                                        else
                                        begin
                                            nstage_next = NS_DONE;
                                        end
                                    end
                                    else if (uc == CH_DOT)
                                    begin
                                        nstage_next = NS_FRAC;
                                    end
                                    else
                                    begin
                                        mag_next    = digit_mag;
                                        nstage_next = NS_INT;
                                    end
                                end
                                NS_FRAC:
                                begin
                                    if ((uc == CH_MINUS) || (uc == CH_DOT))
                                    begin
                                        nstage_next = NS_DONE;
                                    end
                                    else if (frac_reg != 2'd3)
                                    begin
                                        mag_next  = digit_mag;
                                        frac_next = frac_reg + 1'b1;
                                    end
                                end
                                default:
                                begin
                                end
                            endcase
                        end
                    end
                    else if (sp)
                    begin
                        commit_en  = 1'b1;
                        phase_next = PH_SKIP;
                    end
                    else
                    begin
                        err_next   = 1'b1;
                        phase_next = PH_ERR;
                    end
                end
                default:
                begin
                end
            endcase
            if (start_p)
            begin
                letter_next = uc;
                nstage_next = NS_START;
                neg_next    = 1'b0;
                frac_next   = '0;
                vtc_next    = '0;
                mag_next    = '0;
                phase_next  = PH_VALUE;
            end
            if (commit_en && slot.hit)
            begin
                param_next[slot.idx] = commit_val;
                seen_next[slot.idx]  = 1'b1;
            end
        end
    end

    // Fold in the parameter still open when the line ends.
    always_comb
    begin
        lf_param = param_reg;
        lf_seen  = seen_reg;
        if ((phase_reg == PH_VALUE) && slot.hit)
        begin
            lf_param[slot.idx] = commit_val;
            lf_seen[slot.idx]  = 1'b1;
        end
        result.command_word   = cmd_chars_reg;
        result.command_length = cmd_count_reg;
        result.line_valid     = (line_count_reg != '0) && !err_reg;
        result.syntax_error   = err_reg;
        result.present_mask   = lf_seen;
        result.x_value        = lf_param[IDX_X];
        result.y_value        = lf_param[IDX_Y];
        result.z_value        = lf_param[IDX_Z];
        result.feed_value     = lf_param[IDX_F];
        result.speed_value    = lf_param[IDX_S];
        result.pause_value    = lf_param[IDX_P];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_count_reg <= '0;
            phase_reg      <= PH_CMD;
            cmd_chars_reg  <= '0;
            cmd_count_reg  <= '0;
            letter_reg     <= '0;
            nstage_reg     <= NS_START;
            neg_reg        <= 1'b0;
            frac_reg       <= '0;
            vtc_reg        <= '0;
            mag_reg        <= '0;
            err_reg        <= 1'b0;
            seen_reg       <= '0;
            for (int k = 0; k < PARAM_COUNT; k++)
            begin
                param_reg[k] <= '0;
            end
        end
        else
        begin
            line_count_reg <= line_count_next;
            phase_reg      <= phase_next;
            cmd_chars_reg  <= cmd_chars_next;
            cmd_count_reg  <= cmd_count_next;
            letter_reg     <= letter_next;
            nstage_reg     <= nstage_next;
            neg_reg        <= neg_next;
            frac_reg       <= frac_next;
            vtc_reg        <= vtc_next;
            mag_reg        <= mag_next;
            err_reg        <= err_next;
            seen_reg       <= seen_next;
            param_reg      <= param_next;
        end
    end

endmodule

// ===== hw/rtl/gclp_out_stage.sv =====
// Result register of the G-code parser: holds one line result until taken.
// Depends on gclp_pkg and gclp_stream_if.
module gclp_out_stage
    import gclp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          load,
    input  result_t       result,
    output logic          free,
    gclp_stream_if.source out_ch
);

    logic    valid_reg, valid_next;
    result_t data_reg;

    assign free         = !valid_reg || out_ch.ready;
    assign valid_next   = load ? 1'b1 : (out_ch.ready ? 1'b0 : valid_reg);
    assign out_ch.valid = valid_reg;
    assign out_ch.data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result;
        end
    end

endmodule
